[src/swfs_pkg.sv]
// Package for the stop-and-wait frame sender: codes, constants, shared types and the check table.
`timescale 1ns / 1ps

package swfs_pkg;

	// Frame markers and check byte arithmetic.
	localparam logic [7:0] MARK_START = 8'hFE;
	localparam logic [7:0] MARK_END   = 8'hFD;
	localparam int unsigned CHECK_MUL = 32'h80;
	localparam int unsigned CHECK_DIV = 32'h87;

	// Register reset values.
	localparam logic [7:0] RESET_TIMEOUT   = 8'd4;
	localparam logic [7:0] RESET_MAX_TRIES = 8'd8;
	localparam logic [7:0] RESET_ACK       = 8'h88;
	localparam logic [7:0] RESET_NAK       = 8'h55;

	localparam int MAX_RESULTS = 7;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int FRAME_LEN   = 5;

	typedef enum logic [1:0] {
		REQ_MSG  = 2'd0,
		REQ_TICK = 2'd1,
		REQ_RX   = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		KIND_FRAME  = 3'd0,
		KIND_ACKED  = 3'd1,
		KIND_RETRY  = 3'd2,
		KIND_GAVEUP = 3'd3,
		KIND_BUSY   = 3'd4,
		KIND_WAIT   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT   = 2'd0,
		REG_MAX_TRIES = 2'd1,
		REG_ACK       = 2'd2,
		REG_NAK       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] timeout_ticks;
		logic [7:0] max_tries;
		logic [7:0] ack_code;
		logic [7:0] nak_code;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} result_t;

	// All results caused by one input item, in delivery order from entry 0.
	typedef struct packed {
		logic [CNT_W-1:0]                count;
		result_t [MAX_RESULTS-1:0]       items;
	} burst_t;

	typedef logic [7:0] chk_lut_t [256];

	// Check byte (data * 256) mod 135 for every data value, built at elaboration.
	function automatic chk_lut_t build_chk_lut();
		chk_lut_t lut;
		for (int i = 0; i < 256; i++) begin
			lut[i] = 8'((i * 2 * CHECK_MUL) % CHECK_DIV);
		end
		return lut;
	endfunction

	localparam chk_lut_t CHK_LUT = build_chk_lut();

	function automatic burst_t push(burst_t b, kind_t k, logic [7:0] v);
		burst_t r;
		r = b;
		r.items[b.count].kind  = k;
		r.items[b.count].value = v;
		r.count = b.count + CNT_W'(1);
		return r;
	endfunction

	function automatic burst_t push_frame(burst_t b, logic [7:0] seq, logic [7:0] data);
		burst_t r;
		r = push(b, KIND_FRAME, MARK_START);
		r = push(r, KIND_FRAME, seq);
		r = push(r, KIND_FRAME, data);
		r = push(r, KIND_FRAME, CHK_LUT[data]);
		r = push(r, KIND_FRAME, MARK_END);
		return r;
	endfunction

endpackage

[src/swfs_if.sv]
// Channel interfaces for the request input and the result output.
`timescale 1ns / 1ps

interface swfs_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;
	logic       first_of_message;

	modport source (output valid, output req_type, output data_byte, output first_of_message,
		input ready);
	modport sink (input valid, input req_type, input data_byte, input first_of_message,
		output ready);
endinterface

interface swfs_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output kind, output out_byte, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

[src/swfs_engine.sv]
// Input register, protocol state and construction of the result list for one request.
`timescale 1ns / 1ps

module swfs_engine
	import swfs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	swfs_req_if.sink req,
	input  cfg_t   cfg,
	output logic   desc_valid,
	input  logic   desc_ready,
	output burst_t desc
);

	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic [7:0] data_byte_s1;
	logic       first_s1;

	logic       busy_q;
	logic [7:0] held_data_q;
	logic [7:0] held_seq_q;
	logic [7:0] msg_idx_q;
	logic [7:0] try_q;
	logic [7:0] tick_q;
	logic       wait_rep_q;

	logic       busy_d;
	logic [7:0] held_data_d;
	logic [7:0] held_seq_d;
	logic [7:0] msg_idx_d;
	logic [7:0] try_d;
	logic [7:0] tick_d;
	logic       wait_rep_d;

	logic [7:0] tick_inc;
	logic [7:0] try_inc;
	logic [7:0] seq_new;
	logic       adv;

	assign tick_inc = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;
	assign try_inc  = (try_q == 8'hFF) ? try_q : try_q + 8'd1;
	assign seq_new  = (first_s1 ? 8'd0 : msg_idx_q) + 8'd1;

	// An item with no results retires without waiting for the output side.
	assign adv        = valid_s1 && ((desc.count == '0) || desc_ready);
	assign desc_valid = valid_s1 && (desc.count != '0);
	assign req.ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1  <= req.req_type;
			data_byte_s1 <= req.data_byte;
			first_s1     <= req.first_of_message;
		end
	end

	always_comb begin
		desc        = '0;
		busy_d      = busy_q;
		held_data_d = held_data_q;
		held_seq_d  = held_seq_q;
		msg_idx_d   = msg_idx_q;
		try_d       = try_q;
		tick_d      = tick_q;
		wait_rep_d  = wait_rep_q;
		case (req_type_t'(req_type_s1))
			REQ_MSG: begin
				if (busy_q) begin
					desc = push(desc, KIND_BUSY, 8'h00);
				end else begin
					held_data_d = data_byte_s1;
					held_seq_d  = seq_new;
					msg_idx_d   = seq_new;
					try_d       = 8'd0;
					busy_d      = 1'b1;
					tick_d      = 8'd0;
					wait_rep_d  = 1'b0;
					desc = push_frame(desc, seq_new, data_byte_s1);
				end
			end
			REQ_TICK: begin
				if (busy_q) begin
					if (!wait_rep_q) begin
						desc = push(desc, KIND_WAIT, 8'h00);
						wait_rep_d = 1'b1;
					end
					tick_d = tick_inc;
					if (tick_inc >= cfg.timeout_ticks) begin
						try_d = try_inc;
						if (try_inc < cfg.max_tries) begin
							desc = push(desc, KIND_RETRY, 8'h00);
							desc = push_frame(desc, held_seq_q, held_data_q);
							tick_d     = 8'd0;
							wait_rep_d = 1'b0;
						end else begin
							desc = push(desc, KIND_GAVEUP, 8'h00);
							busy_d = 1'b0;
						end
					end
				end
			end
			REQ_RX: begin
				if (busy_q) begin
					// The accept meaning wins when both codes are equal.
					if (data_byte_s1 == cfg.ack_code) begin
						desc = push(desc, KIND_ACKED, 8'h00);
						busy_d = 1'b0;
					end else if (data_byte_s1 == cfg.nak_code) begin
						if (try_q < cfg.max_tries) begin
							desc = push(desc, KIND_RETRY, 8'h00);
							desc = push_frame(desc, held_seq_q, held_data_q);
							tick_d     = 8'd0;
							wait_rep_d = 1'b0;
							try_d      = try_inc;
						end else begin
							desc = push(desc, KIND_GAVEUP, 8'h00);
							busy_d = 1'b0;
						end
					end else if (!wait_rep_q) begin
						desc = push(desc, KIND_WAIT, 8'h00);
						wait_rep_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			held_data_q <= 8'd0;
			held_seq_q  <= 8'd0;
			msg_idx_q   <= 8'd0;
			try_q       <= 8'd0;
			tick_q      <= 8'd0;
			wait_rep_q  <= 1'b0;
		end else if (adv) begin
			busy_q      <= busy_d;
			held_data_q <= held_data_d;
			held_seq_q  <= held_seq_d;
			msg_idx_q   <= msg_idx_d;
			try_q       <= try_d;
			tick_q      <= tick_d;
			wait_rep_q  <= wait_rep_d;
		end
	end

endmodule

[src/swfs_emitter.sv]
// Result register that holds one result list and hands it out one result per transaction.
`timescale 1ns / 1ps

module swfs_emitter
	import swfs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   desc_valid,
	output logic   desc_ready,
	input  burst_t desc,
	swfs_res_if.source res
);

	logic                    bvalid_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        idx_q;
	result_t [MAX_RESULTS-1:0] items_q;
	logic                    is_last;
	logic                    done;

	assign is_last    = (idx_q == count_q - CNT_W'(1));
	assign done       = res.valid && res.ready && is_last;
	assign desc_ready = !bvalid_q || done;

	assign res.valid    = bvalid_q;
	assign res.kind     = items_q[idx_q].kind;
	assign res.out_byte = items_q[idx_q].value;
	assign res.last     = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (desc_ready) begin
			bvalid_q <= desc_valid;
			idx_q    <= '0;
		end else if (res.valid && res.ready) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (desc_ready && desc_valid) begin
			count_q <= desc.count;
			items_q <= desc.items;
		end
	end

endmodule

[src/stop_and_wait_frame_sender.sv]
// Top level of the stop-and-wait frame sender: register port and the two datapath parts.
//
// A message byte sent while idle leaves as a five-byte frame (start marker, sequence, data,
// check byte, end marker); the sender then waits for an accept or reject byte and counts
// timer ticks, retransmitting on reject or timeout until the try limit, then giving up.
// Requests are taken one per cycle into an input register while it is free or passes its item
// on, and each is turned combinationally into its full list of results (none to seven). The
// list waits in a result register that hands out one result per cycle while the output is
// ready, so an item holds the output for one transaction per result (a frame transmission
// has five, a retry six or seven), and an item with no results retires without entering it;
// the output serializer sets the sustained rate. A new request is taken while the previous
// list is still being delivered. Registers lie at byte addresses 0 (timeout ticks), 4 (try
// limit), 8 (accept code) and 12 (reject code) and should only be written while no transaction is outstanding.
`timescale 1ns / 1ps

module stop_and_wait_frame_sender
	import swfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	swfs_req_if.sink    req,
	swfs_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t   cfg_q;
	logic   desc_valid;
	logic   desc_ready;
	burst_t desc;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= RESET_TIMEOUT;
			cfg_q.max_tries     <= RESET_MAX_TRIES;
			cfg_q.ack_code      <= RESET_ACK;
			cfg_q.nak_code      <= RESET_NAK;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_TIMEOUT:   cfg_q.timeout_ticks <= pwdata[7:0];
				REG_MAX_TRIES: cfg_q.max_tries     <= pwdata[7:0];
				REG_ACK:       cfg_q.ack_code      <= pwdata[7:0];
				REG_NAK:       cfg_q.nak_code      <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_TIMEOUT:   prdata = {24'd0, cfg_q.timeout_ticks};
			REG_MAX_TRIES: prdata = {24'd0, cfg_q.max_tries};
			REG_ACK:       prdata = {24'd0, cfg_q.ack_code};
			REG_NAK:       prdata = {24'd0, cfg_q.nak_code};
		endcase
	end

	swfs_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg_q),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc)
	);

	swfs_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc),
		.res        (res)
	);

endmodule
